### rtl/core/mrwm_pkg.sv
// ----------------------------------------------------------------------------
// mrwm_pkg
// Shared types and constants of the message rate window monitor.
// ----------------------------------------------------------------------------
package mrwm_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_QUERY  = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ARRIVE,
        S_CLEAR,
        S_PRUNE_RD,
        S_PRUNE_CHK,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL_START,
        S_MUL_WAIT,
        S_OUT
    } state_t;

    typedef enum logic [2:0] {
        DIV_AVG  = 3'd0,
        DIV_RMIN = 3'd1,
        DIV_RMAX = 3'd2,
        DIV_BW   = 3'd3,
        DIV_LAT  = 3'd4
    } div_sel_t;

    localparam logic CFG_WINDOW = 1'b0;
    localparam logic CFG_FACTOR = 1'b1;

    localparam int TIME_W  = 63;
    localparam int ENTRY_W = 63 + 32 + 32;

    localparam logic [15:0] WINDOW_RESET  = 16'd1000;
    localparam logic [15:0] FACTOR_RESET  = 16'd512;
    localparam logic [15:0] WINDOW_ZERO   = 16'd100;
    localparam logic [15:0] FACTOR_ONE    = 16'd256;
    localparam logic [19:0] NS_PER_MS     = 20'd1000000;
    localparam logic [63:0] NS_PER_S      = 64'd1000000000;
    localparam logic [63:0] RATE_ONE_NS   = 64'd256000000000;
    localparam logic [9:0]  BW_SCALE      = 10'd1000;
    localparam logic [47:0] RATE_ONE      = 48'd256;
    localparam logic [63:0] MAX48         = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] MAX50         = 64'h3_FFFF_FFFF_FFFF;

endpackage

### rtl/core/mrwm_if.sv
// ----------------------------------------------------------------------------
// mrwm_item_if / mrwm_result_if
// Valid/ready channels for requests and results of the monitor.
// ----------------------------------------------------------------------------
interface mrwm_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [62:0]        time_ns;
    logic [31:0]        msg_bytes;
    logic signed [31:0] msg_latency_us;

    modport source (output valid, operation, time_ns, msg_bytes, msg_latency_us,
                    input ready);
    modport sink   (input valid, operation, time_ns, msg_bytes, msg_latency_us,
                    output ready);
endinterface

interface mrwm_result_if;
    logic               valid;
    logic               ready;
    logic [47:0]        rate_avg;
    logic [47:0]        rate_min;
    logic [47:0]        rate_max;
    logic [49:0]        bandwidth;
    logic signed [31:0] latency_avg;
    logic signed [31:0] latency_min;
    logic signed [31:0] latency_max;
    logic [63:0]        message_total;
    logic [63:0]        byte_total;
    logic               drop_flag;
    logic [62:0]        last_gap;
    logic               ring_overflow;

    modport source (output valid, rate_avg, rate_min, rate_max, bandwidth,
                    latency_avg, latency_min, latency_max, message_total,
                    byte_total, drop_flag, last_gap, ring_overflow,
                    input ready);
    modport sink   (input valid, rate_avg, rate_min, rate_max, bandwidth,
                    latency_avg, latency_min, latency_max, message_total,
                    byte_total, drop_flag, last_gap, ring_overflow,
                    output ready);
endinterface

### rtl/core/mrwm_ram.sv
// ----------------------------------------------------------------------------
// mrwm_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/mrwm_div.sv
// ----------------------------------------------------------------------------
// mrwm_div
// Restoring 64 by 64 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrwm_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [64:0] rem_reg;
    logic [63:0] quo_reg;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] shifted;
    logic        fits;

    assign shifted = {rem_reg[63:0], quo_reg[63]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? shifted - {1'b0, den_reg} : shifted;
            quo_reg <= {quo_reg[62:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/mrwm_mul.sv
// ----------------------------------------------------------------------------
// mrwm_mul
// Shift-add multiplier, 64 by 16 bits, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mrwm_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [15:0] b,
    output logic        done,
    output logic [79:0] product
);

    logic [79:0] acc_reg;
    logic [79:0] a_reg;
    logic [15:0] b_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd16;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= {16'd0, a};
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[78:0], 1'b0};
            b_reg <= {1'b0, b_reg[15:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

### rtl/core/message_rate_window_monitor_unit.sv
// ----------------------------------------------------------------------------
// message_rate_window_monitor_unit
// Windowed message rate, bandwidth and latency statistics over a ring.
// ----------------------------------------------------------------------------
// One request at a time. A query first prunes the entries that fell out of the
// window and then scans the entries left in it: during pruning and scanning
// each ring RAM entry is read in a read state (S_PRUNE_RD, S_SCAN_RD) and
// checked in a check state (S_PRUNE_CHK, S_SCAN_CHK). Then one shared 64-bit
// divider runs five divisions at one bit a cycle and a 16-step shift-add
// multiplier forms the two products of the drop compare. The result sits in an
// output register, so the next request is taken while it waits.
module message_rate_window_monitor_unit
    import mrwm_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [15:0]          cfg_data,
    mrwm_item_if.sink            item,
    mrwm_result_if.source        result
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int BW = 32 + CW;
    localparam int LW = 31 + CW;

    state_t state_reg, state_next;

    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;
    logic [62:0]   prev_reg;
    logic [62:0]   gap_reg;
    logic [63:0]   ctot_reg;
    logic [63:0]   btot_reg;
    logic          ovf_reg;
    logic [15:0]   wms_reg;
    logic [15:0]   fac_reg;

    logic [62:0]   t_reg;
    logic [31:0]   bytes_reg;
    logic [31:0]   lat_reg;

    logic [CW-1:0] idx_reg;
    logic [62:0]   first_reg;
    logic [62:0]   last_reg;
    logic [62:0]   gmax_reg;
    logic [62:0]   gmin_reg;
    logic [BW-1:0] bsum_reg;
    logic [LW-1:0] lsum_reg;
    logic [CW-1:0] lcnt_reg;
    logic [30:0]   lmin_reg;
    logic [30:0]   lmax_reg;
    logic [2:0]    sel_reg;
    logic [63:0]   q_reg [5];
    logic [79:0]   p0_reg;
    logic [79:0]   p1_reg;

    logic          out_valid_reg;
    logic [47:0]   avg_out_reg, rmin_out_reg, rmax_out_reg;
    logic [49:0]   bw_out_reg;
    logic [31:0]   lavg_out_reg, lmin_out_reg, lmax_out_reg;
    logic          drop_out_reg;
    logic [63:0]   ctot_out_reg, btot_out_reg;
    logic [62:0]   gap_out_reg;
    logic          ovf_out_reg;

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h,
                                              input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW + 1)'(h) + (CW + 1)'(k);
        if (s >= (CW + 1)'(RING_DEPTH))
        begin
            s = s - (CW + 1)'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // effective register values
    logic [15:0] wms_eff, fac_eff;
    logic [35:0] wns;
    logic [62:0] cut;
    logic        prune_en;

    assign wms_eff  = (wms_reg == 16'd0) ? WINDOW_ZERO : wms_reg;
    assign fac_eff  = (fac_reg > FACTOR_ONE) ? fac_reg : FACTOR_RESET;
    assign wns      = wms_eff * NS_PER_MS;
    assign prune_en = t_reg > 63'(wns);
    assign cut      = t_reg - 63'(wns);

    // ring memory
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [62:0]        rd_time;
    logic [31:0]        rd_bytes;
    logic [31:0]        rd_lat;
    logic               full;

    assign full      = count_reg == CW'(RING_DEPTH);
    assign ram_we    = state_reg == S_ARRIVE;
    assign ram_waddr = full ? head_reg : slot_of(head_reg, count_reg);
    assign ram_raddr = (state_reg == S_PRUNE_RD) ? head_reg : slot_of(head_reg, idx_reg);
    assign rd_time   = ram_rdata[ENTRY_W-1:64];
    assign rd_bytes  = ram_rdata[63:32];
    assign rd_lat    = ram_rdata[31:0];

    mrwm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({t_reg, bytes_reg, lat_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // derived window figures
    logic        n0, n1, span_pos;
    logic [62:0] span;
    logic [15:0] k_mul;
    logic [63:0] denom;

    assign n0       = count_reg == '0;
    assign n1       = count_reg == CW'(1);
    assign span_pos = last_reg > first_reg;
    assign span     = last_reg - first_reg;
    assign k_mul    = n1 ? 16'd1 : ((!n0 && span_pos) ? 16'(count_reg - CW'(1)) : 16'd0);
    assign denom    = n1 ? NS_PER_S : {1'b0, span};

    // shared divider operands
    logic        div_start, div_done;
    logic [63:0] div_num, div_den, div_q;

    always_comb
    begin
        div_num = RATE_ONE_NS;
        div_den = 64'd1;
        case (sel_reg)
            DIV_AVG:
            begin
                div_num = 64'(count_reg - CW'(1)) * RATE_ONE_NS;
                div_den = {1'b0, span};
            end
            DIV_RMIN: div_den = {1'b0, gmax_reg};
            DIV_RMAX: div_den = {1'b0, gmin_reg};
            DIV_BW:
            begin
                div_num = 64'(bsum_reg) * 64'(BW_SCALE);
                div_den = 64'(wms_eff);
            end
            DIV_LAT:
            begin
                div_num = 64'(lsum_reg);
                div_den = 64'(lcnt_reg);
            end
            default:
            begin
                div_num = RATE_ONE_NS;
                div_den = 64'd1;
            end
        endcase
        if (div_den == 64'd0)
        begin
            div_den = 64'd1;
        end
    end

    assign div_start = state_reg == S_DIV_START;

    mrwm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    logic        mul_start, mul_done;
    logic [63:0] mul_a;
    logic [15:0] mul_b;
    logic [79:0] mul_p;

    assign mul_start = state_reg == S_MUL_START;
    assign mul_a     = (sel_reg == 3'd0) ? {1'b0, gap_reg} : denom;
    assign mul_b     = (sel_reg == 3'd0) ? k_mul : fac_eff;

    mrwm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    logic out_free;
    logic last_entry;

    assign out_free   = !out_valid_reg || result.ready;
    assign last_entry = idx_reg == count_reg;
    assign item.ready = state_reg == S_IDLE;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    case (item.operation)
                        OP_ARRIVE: state_next = S_ARRIVE;
                        OP_QUERY:  state_next = S_PRUNE_RD;
                        OP_CLEAR:  state_next = S_CLEAR;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ARRIVE:    state_next = S_IDLE;
            S_CLEAR:     state_next = S_IDLE;
            S_PRUNE_RD:  state_next = (prune_en && !n0) ? S_PRUNE_CHK : S_SCAN_INIT;
            S_PRUNE_CHK: state_next = (rd_time < cut) ? S_PRUNE_RD : S_SCAN_INIT;
            S_SCAN_INIT: state_next = S_SCAN_RD;
            S_SCAN_RD:   state_next = last_entry ? S_DIV_START : S_SCAN_CHK;
            S_SCAN_CHK:  state_next = S_SCAN_RD;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (sel_reg == DIV_LAT) ? S_MUL_START : S_DIV_START;
                end
            end
            S_MUL_START: state_next = S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (sel_reg == 3'd1) ? S_OUT : S_MUL_START;
                end
            end
            S_OUT:       state_next = out_free ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // gap of the current scan entry to the one before
    logic [62:0] g;
    logic        g_pos;

    assign g_pos = (idx_reg != '0) && (rd_time > last_reg);
    assign g     = rd_time - last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            prev_reg      <= '0;
            gap_reg       <= '0;
            ctot_reg      <= '0;
            btot_reg      <= '0;
            ovf_reg       <= 1'b0;
            wms_reg       <= WINDOW_RESET;
            fac_reg       <= FACTOR_RESET;
            out_valid_reg <= 1'b0;
            sel_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WINDOW: wms_reg <= cfg_data;
                    CFG_FACTOR: fac_reg <= cfg_data;
                    default:    wms_reg <= wms_reg;
                endcase
            end
            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_ARRIVE:
                begin
                    if (prev_reg != '0)
                    begin
                        gap_reg <= (t_reg > prev_reg) ? t_reg - prev_reg : '0;
                    end
                    else
                    begin
                        gap_reg <= '0;
                    end
                    if (full)
                    begin
                        head_reg <= slot_of(head_reg, CW'(1));
                        ovf_reg  <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    prev_reg <= t_reg;
                    ctot_reg <= ctot_reg + 64'd1;
                    btot_reg <= btot_reg + 64'(bytes_reg);
                end
                S_CLEAR:
                begin
                    head_reg  <= '0;
                    count_reg <= '0;
                    prev_reg  <= '0;
                    gap_reg   <= '0;
                    ctot_reg  <= '0;
                    btot_reg  <= '0;
                    ovf_reg   <= 1'b0;
                end
                S_PRUNE_CHK:
                begin
                    if (rd_time < cut)
                    begin
                        head_reg  <= slot_of(head_reg, CW'(1));
                        count_reg <= count_reg - CW'(1);
                    end
                end
                S_SCAN_INIT:
                begin
                    idx_reg <= '0;
                    sel_reg <= '0;
                end
                S_SCAN_CHK:  idx_reg <= idx_reg + CW'(1);
                S_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        sel_reg <= (sel_reg == DIV_LAT) ? 3'd0 : sel_reg + 3'd1;
                    end
                end
                S_MUL_WAIT:
                begin
                    if (mul_done)
                    begin
                        sel_reg <= sel_reg + 3'd1;
                    end
                end
                default:
                begin
                    sel_reg <= sel_reg;
                end
            endcase
        end
    end

    // payload datapath
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            t_reg     <= item.time_ns;
            bytes_reg <= item.msg_bytes;
            lat_reg   <= item.msg_latency_us;
        end
        case (state_reg)
            S_SCAN_INIT:
            begin
                first_reg <= '0;
                last_reg  <= '0;
                gmax_reg  <= '0;
                gmin_reg  <= '0;
                bsum_reg  <= '0;
                lsum_reg  <= '0;
                lcnt_reg  <= '0;
                lmin_reg  <= '0;
                lmax_reg  <= '0;
            end
            S_SCAN_CHK:
            begin
                if (idx_reg == '0)
                begin
                    first_reg <= rd_time;
                end
                last_reg <= rd_time;
                if (g_pos)
                begin
                    if (g > gmax_reg)
                    begin
                        gmax_reg <= g;
                    end
                    if (gmin_reg == '0 || g < gmin_reg)
                    begin
                        gmin_reg <= g;
                    end
                end
                bsum_reg <= bsum_reg + BW'(rd_bytes);
                if (!rd_lat[31])
                begin
                    if (lcnt_reg == '0 || rd_lat[30:0] < lmin_reg)
                    begin
                        lmin_reg <= rd_lat[30:0];
                    end
                    if (lcnt_reg == '0 || rd_lat[30:0] > lmax_reg)
                    begin
                        lmax_reg <= rd_lat[30:0];
                    end
                    lsum_reg <= lsum_reg + LW'(rd_lat[30:0]);
                    lcnt_reg <= lcnt_reg + CW'(1);
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    q_reg[sel_reg] <= div_q;
                end
            end
            S_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (sel_reg == 3'd0)
                    begin
                        p0_reg <= mul_p;
                    end
                    else
                    begin
                        p1_reg <= mul_p;
                    end
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    if (n0)
                    begin
                        avg_out_reg  <= '0;
                        rmin_out_reg <= '0;
                        rmax_out_reg <= '0;
                        bw_out_reg   <= '0;
                    end
                    else
                    begin
                        if (n1)
                        begin
                            avg_out_reg  <= RATE_ONE;
                            rmin_out_reg <= RATE_ONE;
                            rmax_out_reg <= RATE_ONE;
                        end
                        else
                        begin
                            if (!span_pos)
                            begin
                                avg_out_reg <= '0;
                            end
                            else
                            begin
                                avg_out_reg <= (q_reg[DIV_AVG] > MAX48) ? MAX48[47:0]
                                                                        : q_reg[DIV_AVG][47:0];
                            end
                            rmin_out_reg <= (gmax_reg != '0) ? q_reg[DIV_RMIN][47:0] : '0;
                            rmax_out_reg <= (gmin_reg != '0) ? q_reg[DIV_RMAX][47:0] : '0;
                        end
                        bw_out_reg <= (q_reg[DIV_BW] > MAX50) ? MAX50[49:0]
                                                              : q_reg[DIV_BW][49:0];
                    end
                    if (lcnt_reg != '0)
                    begin
                        lavg_out_reg <= q_reg[DIV_LAT][31:0];
                        lmin_out_reg <= {1'b0, lmin_reg};
                        lmax_out_reg <= {1'b0, lmax_reg};
                    end
                    else
                    begin
                        lavg_out_reg <= '1;
                        lmin_out_reg <= '1;
                        lmax_out_reg <= '1;
                    end
                    // gap*k*256 against factor*period, both exact
                    drop_out_reg <= (k_mul != '0) && (gap_reg != '0)
                                    && ({p0_reg, 8'd0} > {8'd0, p1_reg});
                    // totals are held with the report while it waits
                    ctot_out_reg <= ctot_reg;
                    btot_out_reg <= btot_reg;
                    gap_out_reg  <= gap_reg;
                    ovf_out_reg  <= ovf_reg;
                end
            end
            default:
            begin
                last_reg <= last_reg;
            end
        endcase
    end

    assign result.valid         = out_valid_reg;
    assign result.rate_avg      = avg_out_reg;
    assign result.rate_min      = rmin_out_reg;
    assign result.rate_max      = rmax_out_reg;
    assign result.bandwidth     = bw_out_reg;
    assign result.latency_avg   = lavg_out_reg;
    assign result.latency_min   = lmin_out_reg;
    assign result.latency_max   = lmax_out_reg;
    assign result.message_total = ctot_out_reg;
    assign result.byte_total    = btot_out_reg;
    assign result.drop_flag     = drop_out_reg;
    assign result.last_gap      = gap_out_reg;
    assign result.ring_overflow = ovf_out_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives arrivals, queries and clears into the rate window monitor and checks
// every report against a behavioral predictor of the ring and its statistics.
// ----------------------------------------------------------------------------
module tb_top
    import mrwm_pkg::*;
();

    localparam int DEPTH = 256;
    localparam int PEND_DEPTH = 1024;
    localparam int ROW_DEPTH = 24;
    localparam logic [63:0] M48 = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] M50 = 64'h3_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [47:0] rate_avg;
        logic [47:0] rate_min;
        logic [47:0] rate_max;
        logic [49:0] bandwidth;
        logic [31:0] latency_avg;
        logic [31:0] latency_min;
        logic [31:0] latency_max;
        logic [63:0] message_total;
        logic [63:0] byte_total;
        logic        drop_flag;
        logic [62:0] last_gap;
        logic        ring_overflow;
    } report_t;

    typedef struct {
        logic [1:0]  op;
        logic [62:0] t;
        logic [31:0] bytes;
        logic [31:0] lat;
        bit          has_fixed;
        report_t     fixed;
    } row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [15:0] cfg_data = 0;

    mrwm_item_if   item_ch();
    mrwm_result_if result_ch();

    message_rate_window_monitor_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .item(item_ch.sink), .result(result_ch.source)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [62:0] arr_q[DEPTH];
    logic [31:0] size_q[DEPTH];
    logic [31:0] lat_q[DEPTH];
    int          head, cnt;
    logic [62:0] prev_arr, gap;
    logic [63:0] msg_tot, byte_tot;
    bit          ovf;
    logic [15:0] win_reg, fac_reg;

    // expected reports in order, written on the request edge, read on the report edge
    report_t pend_q[PEND_DEPTH];
    int      pend_wr = 0;
    int      pend_rd = 0;
    row_t    rows[ROW_DEPTH];
    int      n_rows = 0;
    int      errors = 0;
    bit      idle_en = 1;
    logic [62:0] clock_ns;

    function automatic int slot(int k);
        return (head + k) % DEPTH;
    endfunction

    function automatic void monitor_clear();
        head = 0; cnt = 0; prev_arr = 0; gap = 0;
        msg_tot = 0; byte_tot = 0; ovf = 0;
    endfunction

    function automatic void add_row(row_t rw);
        rows[n_rows] = rw;
        n_rows++;
    endfunction

    function automatic report_t compute_report(logic [62:0] now);
        report_t r;
        logic [63:0] wms, fac, wns, cut, first, last, span, a, b, g, gmax, gmin;
        logic [63:0] bytes, lsum, lcnt, lmin, lmax, kmul, denom, v, bw;
        logic [127:0] lhs, rhs;
        r = '0;
        wms = (win_reg == 0) ? 64'd100 : 64'(win_reg);
        fac = (fac_reg > 256) ? 64'(fac_reg) : 64'd512;
        wns = wms * 64'd1000000;
        if (64'(now) > wns)
        begin
            cut = 64'(now) - wns;
            while (cnt > 0 && 64'(arr_q[head]) < cut)
            begin
                head = slot(1);
                cnt--;
            end
        end
        kmul = 0; denom = 0; bytes = 0; lsum = 0; lcnt = 0; lmin = 0; lmax = 0;
        if (cnt == 1)
        begin
            r.rate_avg = 48'd256; r.rate_min = 48'd256; r.rate_max = 48'd256;
            kmul = 64'd1; denom = 64'd1000000000;
        end
        else if (cnt >= 2)
        begin
            first = 64'(arr_q[slot(0)]);
            last = 64'(arr_q[slot(cnt - 1)]);
            gmax = 0; gmin = 0;
            if (last > first)
            begin
                span = last - first;
                a = (64'(cnt - 1) * 64'd256000000000) / span;
                r.rate_avg = (a > M48) ? M48[47:0] : a[47:0];
                kmul = 64'(cnt - 1); denom = span;
            end
            for (int i = 1; i < cnt; i++)
            begin
                a = 64'(arr_q[slot(i - 1)]);
                b = 64'(arr_q[slot(i)]);
                if (b > a)
                begin
                    g = b - a;
                    if (g > gmax) gmax = g;
                    if (gmin == 0 || g < gmin) gmin = g;
                end
            end
            if (gmax > 0) r.rate_min = 48'(64'd256000000000 / gmax);
            if (gmin > 0) r.rate_max = 48'(64'd256000000000 / gmin);
        end
        for (int i = 0; i < cnt; i++)
        begin
            v = 64'(lat_q[slot(i)]);
            bytes += 64'(size_q[slot(i)]);
            if (v[31] == 0)
            begin
                if (lcnt == 0 || v < lmin) lmin = v;
                if (lcnt == 0 || v > lmax) lmax = v;
                lsum += v;
                lcnt++;
            end
        end
        if (cnt > 0)
        begin
            bw = (bytes * 64'd1000) / wms;
            r.bandwidth = (bw > M50) ? M50[49:0] : bw[49:0];
        end
        if (lcnt > 0)
        begin
            r.latency_avg = 32'(lsum / lcnt);
            r.latency_min = lmin[31:0];
            r.latency_max = lmax[31:0];
        end
        else
        begin
            r.latency_avg = '1; r.latency_min = '1; r.latency_max = '1;
        end
        if (kmul > 0 && gap > 0)
        begin
            lhs = 128'(gap) * 128'(kmul * 64'd256);
            rhs = 128'(fac) * 128'(denom);
            r.drop_flag = lhs > rhs;
        end
        r.message_total = msg_tot;
        r.byte_total = byte_tot;
        r.last_gap = gap;
        r.ring_overflow = ovf;
        return r;
    endfunction

    function automatic bit monitor_step(logic [1:0] op, logic [62:0] t, logic [31:0] bytes,
                                        logic [31:0] lat, output report_t r);
        int s;
        r = '0;
        if (op == OP_ARRIVE)
        begin
            gap = (prev_arr > 0 && t > prev_arr) ? t - prev_arr : '0;
            if (cnt >= DEPTH)
            begin
                head = slot(1);
                cnt = DEPTH - 1;
                ovf = 1;
            end
            s = slot(cnt);
            arr_q[s] = t; size_q[s] = bytes; lat_q[s] = lat;
            cnt++;
            prev_arr = t;
            msg_tot++;
            byte_tot += 64'(bytes);
            return 0;
        end
        if (op == OP_QUERY)
        begin
            r = compute_report(t);
            return 1;
        end
        if (op == OP_CLEAR) monitor_clear();
        return 0;
    endfunction

    task automatic send_request(logic [1:0] op, logic [62:0] t, logic [31:0] bytes,
                                logic [31:0] lat, bit has_fixed, report_t fixed);
        report_t r;
        while (idle_en && $urandom_range(99) < 30)
        begin
            item_ch.valid <= 0;
            @(negedge clk);
        end
        item_ch.valid <= 1;
        item_ch.operation <= op;
        item_ch.time_ns <= t;
        item_ch.msg_bytes <= bytes;
        item_ch.msg_latency_us <= lat;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        if (monitor_step(op, t, bytes, lat, r))
        begin
            if (has_fixed && r != fixed)
            begin
                errors++;
                $display("%0t predictor disagrees with table row exp %h got %h",
                         $time, fixed, r);
            end
            pend_q[pend_wr % PEND_DEPTH] = r;
            pend_wr++;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        item_ch.valid <= 0;
        while (pend_wr != pend_rd) @(negedge clk);
        repeat (900) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
        if (idx == CFG_WINDOW) win_reg = val; else fac_reg = val;
    endtask

    // receiver
    always @(negedge clk)
        result_ch.ready <= (!idle_en) || ($urandom_range(99) >= 30);

    always @(posedge clk)
    begin
        report_t got, want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = {result_ch.rate_avg, result_ch.rate_min, result_ch.rate_max,
                   result_ch.bandwidth, result_ch.latency_avg, result_ch.latency_min,
                   result_ch.latency_max, result_ch.message_total, result_ch.byte_total,
                   result_ch.drop_flag, result_ch.last_gap, result_ch.ring_overflow};
            if (pend_wr == pend_rd)
            begin
                errors++;
                $display("%0t unexpected report %h", $time, got);
            end
            else
            begin
                want = pend_q[pend_rd % PEND_DEPTH];
                pend_rd++;
                if (got.rate_avg != want.rate_avg)
                    $display("%0t rate_avg exp %0d got %0d", $time, want.rate_avg, got.rate_avg);
                if (got.rate_min != want.rate_min)
                    $display("%0t rate_min exp %0d got %0d", $time, want.rate_min, got.rate_min);
                if (got.rate_max != want.rate_max)
                    $display("%0t rate_max exp %0d got %0d", $time, want.rate_max, got.rate_max);
                if (got.bandwidth != want.bandwidth)
                    $display("%0t bandwidth exp %0d got %0d", $time, want.bandwidth,
                             got.bandwidth);
                if (got.latency_avg != want.latency_avg)
                    $display("%0t latency_avg exp %0d got %0d", $time,
                             $signed(want.latency_avg), $signed(got.latency_avg));
                if (got.latency_min != want.latency_min)
                    $display("%0t latency_min exp %0d got %0d", $time,
                             $signed(want.latency_min), $signed(got.latency_min));
                if (got.latency_max != want.latency_max)
                    $display("%0t latency_max exp %0d got %0d", $time,
                             $signed(want.latency_max), $signed(got.latency_max));
                if (got.message_total != want.message_total)
                    $display("%0t message_total exp %0d got %0d", $time,
                             want.message_total, got.message_total);
                if (got.byte_total != want.byte_total)
                    $display("%0t byte_total exp %0d got %0d", $time, want.byte_total,
                             got.byte_total);
                if (got.drop_flag != want.drop_flag)
                    $display("%0t drop_flag exp %0d got %0d", $time, want.drop_flag,
                             got.drop_flag);
                if (got.last_gap != want.last_gap)
                    $display("%0t last_gap exp %0d got %0d", $time, want.last_gap,
                             got.last_gap);
                if (got.ring_overflow != want.ring_overflow)
                    $display("%0t ring_overflow exp %0d got %0d", $time,
                             want.ring_overflow, got.ring_overflow);
                if (got != want) errors++;
            end
        end
    end

    initial
    begin
        #200_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic random_arrival(int kind);
        logic [62:0] t;
        logic [31:0] lat;
        case (kind)
            0: t = clock_ns + 63'($urandom_range(20_000_000));
            1: t = clock_ns + 63'($urandom_range(2_000_000_000));
            2: t = clock_ns;
            3: t = clock_ns - 63'($urandom_range(1_000_000));
            default: t = 63'({$urandom, $urandom});
        endcase
        lat = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(100_000));
        clock_ns = t;
        send_request(OP_ARRIVE, t, ($urandom_range(3) == 0) ? $urandom :
                     32'($urandom_range(5000)), lat, 0, '0);
    endtask

    initial
    begin
        row_t rw;
        report_t none_rep;
        item_ch.valid = 0;
        item_ch.operation = OP_ARRIVE;
        item_ch.time_ns = 0;
        item_ch.msg_bytes = 0;
        item_ch.msg_latency_us = 0;
        result_ch.ready = 0;
        monitor_clear();
        win_reg = 1000; fac_reg = 512;
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // query on an empty monitor, then edge-case arrivals, an invalid op, clears and queries
        none_rep = '0;
        none_rep.latency_avg = '1; none_rep.latency_min = '1; none_rep.latency_max = '1;
        rw = '{OP_QUERY, 63'd5, 32'd0, 32'd0, 1, none_rep}; add_row(rw);
        rw = '{OP_ARRIVE, 63'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, '0}; add_row(rw);
        rw = '{OP_ARRIVE, 63'd1000, 32'd0, 32'h8000_0000, 0, '0}; add_row(rw);
        rw = '{OP_ARRIVE, 63'd500, 32'd10, 32'd0, 0, '0}; add_row(rw);
        rw = '{OP_ARRIVE, 63'd500, 32'd10, 32'hFFFF_FFFF, 0, '0}; add_row(rw);
        rw = '{OP_QUERY, 63'd1000, 32'd0, 32'd0, 0, '0}; add_row(rw);
        rw = '{2'd3, 63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0};
        add_row(rw);
        rw = '{OP_CLEAR, 63'd0, 32'd0, 32'd0, 0, '0}; add_row(rw);
        rw = '{OP_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 1, none_rep};
        add_row(rw);
        rw = '{OP_ARRIVE, 63'd10_000_000, 32'd100, 32'd50, 0, '0}; add_row(rw);
        rw = '{OP_ARRIVE, 63'd20_000_000, 32'd100, 32'd70, 0, '0}; add_row(rw);
        rw = '{OP_ARRIVE, 63'd90_000_000, 32'd100, 32'd10, 0, '0}; add_row(rw);
        rw = '{OP_QUERY, 63'd95_000_000, 32'd0, 32'd0, 0, '0}; add_row(rw);
        rw = '{OP_QUERY, 63'd5_000_000_000, 32'd0, 32'd0, 0, '0}; add_row(rw);
        rw = '{OP_ARRIVE, 63'h7FFF_FFFF_FFFF_FFFF, 32'd1, 32'd1, 0, '0}; add_row(rw);
        rw = '{OP_QUERY, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0, 32'd0, 0, '0}; add_row(rw);
        rw = '{OP_CLEAR, 63'd0, 32'd0, 32'd0, 0, '0}; add_row(rw);
        for (int i = 0; i < n_rows; i++)
            send_request(rows[i].op, rows[i].t, rows[i].bytes, rows[i].lat,
                         rows[i].has_fixed, rows[i].fixed);
        drain();

        // zero window, factor at one, then full ring overflow
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_FACTOR, 16'd256);
        clock_ns = 63'd1_000;
        for (int i = 0; i < 270; i++)
        begin
            if (i == 40) idle_en = 0;
            if (i == 200) idle_en = 1;
            clock_ns += 63'($urandom_range(1_000, 300_000));
            send_request(OP_ARRIVE, clock_ns, $urandom, $urandom, 0, '0);
            if (i % 60 == 59)
                send_request(OP_QUERY, clock_ns, 0, 0, 0, '0);
        end
        send_request(OP_QUERY, clock_ns + 63'd1, 0, 0, 0, '0);
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_WINDOW, 16'd65535);
                    write_reg(CFG_FACTOR, 16'd65535);
                end
                1:
                begin
                    write_reg(CFG_WINDOW, 16'd1);
                    write_reg(CFG_FACTOR, 16'd257);
                end
                2:
                begin
                    write_reg(CFG_WINDOW, 16'd50);
                    write_reg(CFG_FACTOR, 16'd300);
                end
                3:
                begin
                    write_reg(CFG_WINDOW, 16'($urandom_range(1, 3000)));
                    write_reg(CFG_FACTOR, 16'($urandom));
                end
                default:
                begin
                    write_reg(CFG_WINDOW, 16'd1000);
                    write_reg(CFG_FACTOR, 16'd512);
                end
            endcase
            send_request(OP_CLEAR, 0, 0, 0, 0, '0);
            clock_ns = 63'($urandom_range(1, 1_000_000_000));
            for (int i = 0; i < 50; i++)
            begin
                int pick;
                pick = $urandom_range(99);
                if (pick < 65) random_arrival($urandom_range(99) < 90 ?
                                              $urandom_range(1) : $urandom_range(2, 4));
                else if (pick < 95)
                    send_request(OP_QUERY, clock_ns + 63'($urandom_range(100_000_000)),
                                 $urandom, $urandom, 0, '0);
                else if (pick < 98) send_request(OP_CLEAR, 0, 0, 0, 0, '0);
                else send_request(2'd3, 63'({$urandom, $urandom}), $urandom, $urandom, 0, '0);
            end
            send_request(OP_QUERY, clock_ns, 0, 0, 0, '0);
            drain();
        end
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
